FILE: design/gso_pkg.sv
// shared types and constants for the gram-schmidt orthonormalizer
// used by gso_root_div and gram_schmidt_orthonormalize; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gso_pkg;

  // fixed field widths of the channels
  localparam int DATA_WIDTH   = 32;
  localparam int THR_WIDTH    = 16;
  localparam int IDX_WIDTH    = 2;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [THR_WIDTH-1:0] THR_RESET = 16'd1;

  // position of a vector inside a set of three
  typedef enum logic [IDX_WIDTH-1:0] {
    POS_FIRST  = 2'd0,
    POS_SECOND = 2'd1,
    POS_THIRD  = 2'd2
  } pos_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DOT,
    ST_PROJ,
    ST_SQ,
    ST_ROOT_GO,
    ST_ROOT,
    ST_DIV,
    ST_OUT
  } state_t;

  // operations of the shift/subtract unit
  typedef enum logic {
    OP_ROOT,
    OP_DIV
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] in_x;
    logic signed [DATA_WIDTH-1:0] in_y;
    logic signed [DATA_WIDTH-1:0] in_z;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] out_x;
    logic signed [DATA_WIDTH-1:0] out_y;
    logic signed [DATA_WIDTH-1:0] out_z;
    logic [IDX_WIDTH-1:0]         basis_index;
    logic                         was_zero;
    logic                         last_of_set;
  } out_item_t;

endpackage

`default_nettype wire

FILE: design/gso_root_div.sv
// iterative shift/subtract unit: integer square root or unsigned division
// one result bit per cycle; depends on gso_pkg
`timescale 1ns / 1ps
`default_nettype none

module gso_root_div #(
  parameter int FRAC_BITS = gso_pkg::FRAC_BITS_DEF
) (
  input  wire                                      clk,
  input  wire                                      rst_n,
  input  wire gso_pkg::unit_ctl_t                  ctl,
  output gso_pkg::unit_sts_t                       sts,
  input  wire [2*gso_pkg::DATA_WIDTH+1:0]          radicand,
  input  wire [gso_pkg::DATA_WIDTH-1:0]            num_mag,
  input  wire [gso_pkg::DATA_WIDTH:0]              divisor,
  output logic [gso_pkg::DATA_WIDTH+FRAC_BITS-1:0] result
);

  localparam int W   = gso_pkg::DATA_WIDTH;
  localparam int SQW = 2 * W + 2;
  localparam int RW  = W + 1;
  localparam int NW  = W + FRAC_BITS;
  localparam int CW  = $clog2(NW + 1);

  logic [SQW-1:0]  a_r;
  logic [RW+1:0]   rem_r;
  logic [NW-1:0]   res_r;
  logic [RW-1:0]   dsr_r;
  logic [CW-1:0]   cnt_r;
  logic            busy_r;
  logic            done_r;
  gso_pkg::unit_op_t op_r;

  logic [RW+1:0] cur;
  logic [RW+1:0] trial;
  logic [RW+1:0] diff;
  logic          ge;

  // shared compare and subtract
  always_comb begin
    if (op_r == gso_pkg::OP_ROOT) begin
      cur   = {rem_r[RW-1:0], a_r[SQW-1 -: 2]};
      trial = {res_r[RW-1:0], 2'b01};
    end else begin
      cur   = {rem_r[RW:0], a_r[SQW-1]};
      trial = {2'b00, dsr_r};
    end
    ge   = cur >= trial;
    diff = cur - trial;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r && ctl.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (!busy_r && ctl.start) begin
      op_r  <= ctl.op;
      rem_r <= '0;
      res_r <= '0;
      dsr_r <= divisor;
      if (ctl.op == gso_pkg::OP_ROOT) begin
        a_r   <= radicand;
        cnt_r <= CW'(RW);
      end else begin
        a_r   <= {num_mag, {FRAC_BITS{1'b0}}, {(SQW-NW){1'b0}}};
        cnt_r <= CW'(NW);
      end
    end else if (busy_r) begin
      rem_r <= ge ? diff : cur;
      res_r <= {res_r[NW-2:0], ge};
      cnt_r <= cnt_r - CW'(1);
      if (op_r == gso_pkg::OP_ROOT) begin
        a_r <= {a_r[SQW-3:0], 2'b00};
      end else begin
        a_r <= {a_r[SQW-2:0], 1'b0};
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign result   = res_r;

endmodule

`default_nettype wire

FILE: design/gram_schmidt_orthonormalize.sv
// gram-schmidt orthonormalizer for sets of three 3d vectors, q-format fixed point
// depends on gso_pkg and gso_root_div
//
// usage: vectors enter on the in_ channel (in_valid / in_stall, in_data),
// three to a set; each vector gives one basis vector on the out_ channel
// (out_valid / out_stall, out_data) with its position, a zero flag and an
// end-of-set flag. in_stall is high from the transfer of a vector until its
// result has been taken, so one vector is in work at a time.
// the time per vector is longest for the third vector of a set and is set
// mostly by the shared shift/subtract unit: one root of DATA_WIDTH+1
// steps and three divisions of DATA_WIDTH+FRAC_BITS steps, plus the
// products on the one shared multiplier.
// the result sits in an output register; while out_stall is high it holds
// and no new vector is taken.
// cfg_we / cfg_wdata write the zero threshold; write it only when idle.
// reset (synchronous, rst_n low) returns to the first vector of a set and
// sets the threshold to 1; the stored basis is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module gram_schmidt_orthonormalize #(
  parameter int FRAC_BITS = gso_pkg::FRAC_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire gso_pkg::in_item_t           in_data,
  output logic                             out_valid,
  input  wire                              out_stall,
  output gso_pkg::out_item_t               out_data,
  input  wire                              cfg_we,
  input  wire [gso_pkg::THR_WIDTH-1:0]     cfg_wdata
);

  localparam int W   = gso_pkg::DATA_WIDTH;
  localparam int SQW = 2 * W + 2;
  localparam int RW  = W + 1;
  localparam int NW  = W + FRAC_BITS;

  localparam logic signed [2*W-1:0] WMAX = {{(W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [2*W-1:0] WMIN = {{(W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic [NW-1:0] QMAX = {{(NW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [NW-1:0] QMIN = {{(NW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

  gso_pkg::state_t state_r, state_nxt;
  gso_pkg::pos_t   pos_r;

  logic [2:0]              cnt_r;
  logic                    k_r;
  logic                    ph_r;
  logic signed [W-1:0]     v_r [3];
  logic signed [W-1:0]     w_r [3];
  logic signed [W-1:0]     r_r [3];
  logic signed [W-1:0]     b_r [6];
  logic signed [W-1:0]     d0_r;
  logic signed [W-1:0]     d1_r;
  logic signed [W+1:0]     acc_r;
  logic signed [2*W-1:0]   prod_r;
  logic [SQW-1:0]          sq_r;
  logic [RW-1:0]           len_r;
  logic                    zero_r;
  logic                    out_valid_r;
  logic [gso_pkg::THR_WIDTH-1:0] thr_r;

  gso_pkg::unit_ctl_t unit_ctl;
  gso_pkg::unit_sts_t unit_sts;
  logic [NW-1:0]      unit_res;
  logic [W-1:0]       div_mag;
  logic [RW-1:0]      div_len;

  logic signed [W-1:0]   opa;
  logic signed [W-1:0]   opb;
  logic signed [W-1:0]   ms;
  logic signed [W+1:0]   acc_sum;
  logic [1:0]            vi;
  logic [2:0]            bi;
  logic [1:0]            mi;
  logic                  last_k;
  logic [2:0]            last_dot;
  logic                  root_zero;
  logic [NW-1:0]         q;
  logic                  q_neg;
  logic signed [W-1:0]   q_sat;

  // saturate a wide signed value to the data width
  function automatic logic signed [W-1:0] sat_w(input logic signed [2*W-1:0] v);
    logic signed [W-1:0] s;
    if (v > WMAX) begin
      s = WMAX[W-1:0];
    end else if (v < WMIN) begin
      s = WMIN[W-1:0];
    end else begin
      s = v[W-1:0];
    end
    return s;
  endfunction

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : W'(v);
  endfunction

  // shift/subtract unit for root and divisions
  gso_root_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_root_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (unit_ctl),
    .sts      (unit_sts),
    .radicand (sq_r),
    .num_mag  (div_mag),
    .divisor  (div_len),
    .result   (unit_res)
  );

  // index helpers
  always_comb begin
    vi       = (cnt_r >= 3'd3) ? 2'(cnt_r - 3'd3) : cnt_r[1:0];
    bi       = k_r ? (cnt_r + 3'd3) : cnt_r;
    last_k   = (pos_r != gso_pkg::POS_THIRD) || k_r;
    last_dot = (pos_r == gso_pkg::POS_THIRD) ? 3'd5 : 3'd2;
    mi       = (state_r == gso_pkg::ST_ROOT) ? 2'd0 : 2'(cnt_r + 3'd1);
  end

  // shared multiplier operands
  always_comb begin
    opa = '0;
    opb = '0;
    case (state_r)
      gso_pkg::ST_DOT: begin
        opa = b_r[cnt_r];
        opb = v_r[vi];
      end
      gso_pkg::ST_PROJ: begin
        opa = k_r ? d1_r : d0_r;
        opb = b_r[bi];
      end
      gso_pkg::ST_SQ: begin
        opa = w_r[cnt_r[1:0]];
        opb = w_r[cnt_r[1:0]];
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // product post-processing and accumulation
  always_comb begin
    ms        = sat_w(prod_r >>> FRAC_BITS);
    acc_sum   = acc_r + (W+2)'(ms);
    root_zero = unit_res[RW-1:0] <= RW'(thr_r);
    q         = unit_res;
    q_neg     = w_r[cnt_r[1:0]][W-1];
    if (!q_neg) begin
      q_sat = (q > QMAX) ? WMAX[W-1:0] : q[W-1:0];
    end else begin
      q_sat = (q > QMIN) ? WMIN[W-1:0] : W'(-q[W-1:0]);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gso_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (pos_r == gso_pkg::POS_FIRST) ? gso_pkg::ST_SQ : gso_pkg::ST_DOT;
        end
      end
      gso_pkg::ST_DOT: begin
        if (ph_r && cnt_r == last_dot) state_nxt = gso_pkg::ST_PROJ;
      end
      gso_pkg::ST_PROJ: begin
        if (ph_r && last_k && cnt_r == 3'd2) state_nxt = gso_pkg::ST_SQ;
      end
      gso_pkg::ST_SQ: begin
        if (ph_r && cnt_r == 3'd2) state_nxt = gso_pkg::ST_ROOT_GO;
      end
      gso_pkg::ST_ROOT_GO: begin
        state_nxt = gso_pkg::ST_ROOT;
      end
      gso_pkg::ST_ROOT: begin
        if (unit_sts.done) state_nxt = root_zero ? gso_pkg::ST_OUT : gso_pkg::ST_DIV;
      end
      gso_pkg::ST_DIV: begin
        if (unit_sts.done && cnt_r == 3'd2) state_nxt = gso_pkg::ST_OUT;
      end
      gso_pkg::ST_OUT: begin
        if (!out_stall) state_nxt = gso_pkg::ST_IDLE;
      end
      default: state_nxt = gso_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    unit_ctl.start = 1'b0;
    unit_ctl.op    = gso_pkg::OP_DIV;
    div_mag        = mag(w_r[mi]);
    div_len        = (state_r == gso_pkg::ST_ROOT) ? unit_res[RW-1:0] : len_r;
    in_stall       = (state_r != gso_pkg::ST_IDLE);
    unique case (state_r)
      gso_pkg::ST_ROOT_GO: begin
        unit_ctl.start = 1'b1;
        unit_ctl.op    = gso_pkg::OP_ROOT;
      end
      gso_pkg::ST_ROOT: begin
        unit_ctl.start = unit_sts.done && !root_zero;
      end
      gso_pkg::ST_DIV: begin
        unit_ctl.start = unit_sts.done && cnt_r != 3'd2;
      end
      default: begin
        unit_ctl.start = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gso_pkg::ST_IDLE;
      pos_r       <= gso_pkg::POS_FIRST;
      out_valid_r <= 1'b0;
      thr_r       <= gso_pkg::THR_RESET;
      ph_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) thr_r <= cfg_wdata;
      if (state_r == gso_pkg::ST_DOT || state_r == gso_pkg::ST_PROJ ||
          state_r == gso_pkg::ST_SQ) begin
        ph_r <= !ph_r;
      end else begin
        ph_r <= 1'b0;
      end
      if (state_r == gso_pkg::ST_ROOT && unit_sts.done && root_zero) begin
        out_valid_r <= 1'b1;
      end else if (state_r == gso_pkg::ST_DIV && unit_sts.done && cnt_r == 3'd2) begin
        out_valid_r <= 1'b1;
      end else if (state_r == gso_pkg::ST_OUT && !out_stall) begin
        out_valid_r <= 1'b0;
        unique case (pos_r)
          gso_pkg::POS_FIRST:  pos_r <= gso_pkg::POS_SECOND;
          gso_pkg::POS_SECOND: pos_r <= gso_pkg::POS_THIRD;
          default:             pos_r <= gso_pkg::POS_FIRST;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= opa * opb;
    case (state_r)
      gso_pkg::ST_IDLE: begin
        v_r[0] <= in_data.in_x;
        v_r[1] <= in_data.in_y;
        v_r[2] <= in_data.in_z;
        w_r[0] <= in_data.in_x;
        w_r[1] <= in_data.in_y;
        w_r[2] <= in_data.in_z;
        cnt_r  <= 3'd0;
        k_r    <= 1'b0;
        acc_r  <= '0;
        sq_r   <= '0;
      end
      // dot products of the stored basis with the input
      gso_pkg::ST_DOT: begin
        if (ph_r) begin
          if (cnt_r == 3'd2 || cnt_r == 3'd5) begin
            acc_r <= '0;
            if (cnt_r == 3'd2) d0_r <= sat_w((2*W)'(acc_sum));
            else               d1_r <= sat_w((2*W)'(acc_sum));
          end else begin
            acc_r <= acc_sum;
          end
          cnt_r <= (cnt_r == last_dot) ? 3'd0 : cnt_r + 3'd1;
        end
      end
      // remove projections, one component at a time
      gso_pkg::ST_PROJ: begin
        if (ph_r) begin
          if (last_k) begin
            w_r[cnt_r[1:0]] <= sat_w((2*W)'(v_r[cnt_r[1:0]]) -
                                     (2*W)'(sat_w((2*W)'(acc_sum))));
            acc_r <= '0;
            k_r   <= 1'b0;
            cnt_r <= (cnt_r == 3'd2) ? 3'd0 : cnt_r + 3'd1;
          end else begin
            acc_r <= acc_sum;
            k_r   <= 1'b1;
          end
        end
      end
      // sum of squares
      gso_pkg::ST_SQ: begin
        if (ph_r) begin
          sq_r  <= sq_r + SQW'(unsigned'(prod_r));
          cnt_r <= (cnt_r == 3'd2) ? 3'd0 : cnt_r + 3'd1;
        end
      end
      gso_pkg::ST_ROOT: begin
        if (unit_sts.done) begin
          len_r  <= unit_res[RW-1:0];
          zero_r <= root_zero;
          cnt_r  <= 3'd0;
          if (root_zero) begin
            r_r[0] <= w_r[0];
            r_r[1] <= w_r[1];
            r_r[2] <= w_r[2];
          end
        end
      end
      gso_pkg::ST_DIV: begin
        if (unit_sts.done) begin
          r_r[cnt_r[1:0]] <= q_sat;
          cnt_r <= cnt_r + 3'd1;
        end
      end
      // keep u0 and u1 for later vectors of the set
      gso_pkg::ST_OUT: begin
        if (!out_stall) begin
          if (pos_r == gso_pkg::POS_FIRST) begin
            b_r[0] <= r_r[0];
            b_r[1] <= r_r[1];
            b_r[2] <= r_r[2];
          end else if (pos_r == gso_pkg::POS_SECOND) begin
            b_r[3] <= r_r[0];
            b_r[4] <= r_r[1];
            b_r[5] <= r_r[2];
          end
        end
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

  // result register
  assign out_valid            = out_valid_r;
  assign out_data.out_x       = r_r[0];
  assign out_data.out_y       = r_r[1];
  assign out_data.out_z       = r_r[2];
  assign out_data.basis_index = pos_r;
  assign out_data.was_zero    = zero_r;
  assign out_data.last_of_set = (pos_r == gso_pkg::POS_THIRD);

  // checks
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_out_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == gso_pkg::ST_OUT)
    else $error("result valid outside output state");

  a_unit_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    unit_ctl.start |-> !unit_sts.busy)
    else $error("unit started while busy");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.basis_index != 2'd3)
    else $error("basis index out of range");

endmodule

`default_nettype wire
